>>> sv/pgl_pkg.sv
`timescale 1ns / 1ps

package pgl_pkg;

  // default pool geometry
  localparam int unsigned GROUPS_DEF   = 256;
  localparam int unsigned OWNERS_DEF   = 64;
  localparam int unsigned SEGMENTS_DEF = 512;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_ALLOC_RSV = 2'd1,
    OP_FREE      = 2'd2,
    OP_RESERVE   = 2'd3
  } pgl_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_UNLINK,
    ST_ENTRY,
    ST_RELINK
  } pgl_state_e;

  // field write enables of the group table
  typedef struct packed {
    logic nxt;
    logic prv;
    logic attr;
  } pgl_we_t;

endpackage

>>> sv/pgl_mem.sv
`timescale 1ns / 1ps

module pgl_mem #(
  parameter int unsigned GROUPS   = pgl_pkg::GROUPS_DEF,
  parameter int unsigned OWNERS   = pgl_pkg::OWNERS_DEF,
  parameter int unsigned SEGMENTS = pgl_pkg::SEGMENTS_DEF,
  localparam int unsigned IdxW  = $clog2(GROUPS),
  localparam int unsigned LinkW = $clog2(GROUPS + 1),
  localparam int unsigned OwnW  = $clog2(OWNERS),
  localparam int unsigned SegW  = $clog2(SEGMENTS)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [LinkW-1:0] rd_next_o,
  output logic [LinkW-1:0] rd_prev_o,
  output logic [OwnW-1:0]  rd_owner_o,
  output logic [SegW-1:0]  rd_seg_o,
  output logic             rd_inl_o,
  output logic             rd_pin_o,
  input  pgl_pkg::pgl_we_t we_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [LinkW-1:0] wr_next_i,
  input  logic [LinkW-1:0] wr_prev_i,
  input  logic [OwnW-1:0]  wr_owner_i,
  input  logic [SegW-1:0]  wr_seg_i,
  input  logic             wr_inl_i,
  input  logic             wr_pin_i
);
  import pgl_pkg::*;

  logic [LinkW-1:0] next_mem  [GROUPS];
  logic [LinkW-1:0] prev_mem  [GROUPS];
  logic [OwnW-1:0]  owner_mem [GROUPS];
  logic [SegW-1:0]  seg_mem   [GROUPS];
  logic             inl_mem   [GROUPS];
  logic             pin_mem   [GROUPS];

  logic [LinkW-1:0] rd_next_q;
  logic [LinkW-1:0] rd_prev_q;
  logic [OwnW-1:0]  rd_owner_q;
  logic [SegW-1:0]  rd_seg_q;
  logic             rd_inl_q;
  logic             rd_pin_q;

  // one write address, per-field enables
  always_ff @(posedge clk_i) begin
    if (we_i.nxt) begin
      next_mem[wr_addr_i] <= wr_next_i;
    end
    if (we_i.prv) begin
      prev_mem[wr_addr_i] <= wr_prev_i;
    end
    if (we_i.attr) begin
      owner_mem[wr_addr_i] <= wr_owner_i;
      seg_mem[wr_addr_i]   <= wr_seg_i;
      inl_mem[wr_addr_i]   <= wr_inl_i;
      pin_mem[wr_addr_i]   <= wr_pin_i;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_next_q  <= next_mem[rd_addr_i];
      rd_prev_q  <= prev_mem[rd_addr_i];
      rd_owner_q <= owner_mem[rd_addr_i];
      rd_seg_q   <= seg_mem[rd_addr_i];
      rd_inl_q   <= inl_mem[rd_addr_i];
      rd_pin_q   <= pin_mem[rd_addr_i];
    end
  end

  assign rd_next_o  = rd_next_q;
  assign rd_prev_o  = rd_prev_q;
  assign rd_owner_o = rd_owner_q;
  assign rd_seg_o   = rd_seg_q;
  assign rd_inl_o   = rd_inl_q;
  assign rd_pin_o   = rd_pin_q;

endmodule

>>> sv/page_group_lru_allocator.sv
`timescale 1ns / 1ps
// channel   | signals                                         | handshake
// ----------+-------------------------------------------------+--------------------------
// command   | operation_i owner_id_i segment_i entry_index_i  | taken when start_i & !busy_o
// result    | status_o group_index_o evicted_o evicted_owner_o | one cycle, marked by done_o
//           | evicted_segment_o reserved_count_o              |
//
// Every item takes one read of the group entry and up to four field writes through the
// single write port of the table before the next item can be accepted.
// The result shows on done_o in the cycle after the last write, while a new item may start.
// After reset the table is initialized one entry a cycle, with busy_o high until every entry is written.
// The receiver cannot stall; results are never held back.

module page_group_lru_allocator #(
  parameter int unsigned GROUPS   = pgl_pkg::GROUPS_DEF,
  parameter int unsigned OWNERS   = pgl_pkg::OWNERS_DEF,
  parameter int unsigned SEGMENTS = pgl_pkg::SEGMENTS_DEF,
  localparam int unsigned IdxW  = $clog2(GROUPS),
  localparam int unsigned CntW  = $clog2(GROUPS + 1),
  localparam int unsigned OwnW  = $clog2(OWNERS),
  localparam int unsigned SegW  = $clog2(SEGMENTS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [1:0]      operation_i,
  input  logic [OwnW-1:0] owner_id_i,
  input  logic [SegW-1:0] segment_i,
  input  logic [IdxW-1:0] entry_index_i,
  output logic            done_o,
  output logic            status_o,
  output logic [IdxW-1:0] group_index_o,
  output logic            evicted_o,
  output logic [OwnW-1:0] evicted_owner_o,
  output logic [SegW-1:0] evicted_segment_o,
  output logic [CntW-1:0] reserved_count_o
);
  import pgl_pkg::*;

  localparam int unsigned LinkW = $clog2(GROUPS + 1);
  localparam logic [LinkW-1:0] LinkNone = LinkW'(GROUPS);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(GROUPS - 1);

  pgl_state_e       state_q, state_d;
  logic [IdxW-1:0]  init_q, init_d;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             skip_q, skip_d;
  logic             done_q, done_d;

  pgl_op_e          op_q, op_d;
  logic [OwnW-1:0]  owner_q, owner_d;
  logic [SegW-1:0]  seg_q, seg_d;
  logic [IdxW-1:0]  tgt_q, tgt_d;

  logic             status_q, status_d;
  logic [IdxW-1:0]  grp_q, grp_d;
  logic             ev_q, ev_d;
  logic [OwnW-1:0]  evown_q, evown_d;
  logic [SegW-1:0]  evseg_q, evseg_d;

  // table ports
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [LinkW-1:0] rd_next, rd_prev;
  logic [OwnW-1:0]  rd_owner;
  logic [SegW-1:0]  rd_seg;
  logic             rd_inl, rd_pin;
  pgl_we_t          we;
  logic [IdxW-1:0]  wr_addr;
  logic [LinkW-1:0] wr_next, wr_prev;
  logic [OwnW-1:0]  wr_owner;
  logic [SegW-1:0]  wr_seg;
  logic             wr_inl, wr_pin;

  // decoded command fields
  pgl_op_e          in_op;
  logic             in_alloc;
  logic             alloc_q;
  logic [OwnW-1:0]  owner_wrap;
  logic [SegW-1:0]  seg_wrap;

  assign in_op    = pgl_op_e'(operation_i);
  assign in_alloc = (in_op == OP_ALLOC) || (in_op == OP_ALLOC_RSV);
  assign alloc_q  = (op_q == OP_ALLOC) || (op_q == OP_ALLOC_RSV);

  // fold owner and segment into range
  assign owner_wrap = ((OwnW + 1)'(owner_id_i) >= (OwnW + 1)'(OWNERS)) ?
                      owner_id_i - OwnW'(OWNERS) : owner_id_i;
  assign seg_wrap   = ((SegW + 1)'(segment_i) >= (SegW + 1)'(SEGMENTS)) ?
                      segment_i - SegW'(SEGMENTS) : segment_i;

  pgl_mem #(
    .GROUPS   (GROUPS),
    .OWNERS   (OWNERS),
    .SEGMENTS (SEGMENTS)
  ) u_mem (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_next_o  (rd_next),
    .rd_prev_o  (rd_prev),
    .rd_owner_o (rd_owner),
    .rd_seg_o   (rd_seg),
    .rd_inl_o   (rd_inl),
    .rd_pin_o   (rd_pin),
    .we_i       (we),
    .wr_addr_i  (wr_addr),
    .wr_next_i  (wr_next),
    .wr_prev_i  (wr_prev),
    .wr_owner_i (wr_owner),
    .wr_seg_i   (wr_seg),
    .wr_inl_i   (wr_inl),
    .wr_pin_i   (wr_pin)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      head_q <= LinkW'(GROUPS - 1);
      tail_q <= '0;
      cnt_q  <= '0;
      skip_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      init_q <= init_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
      done_q <= done_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    owner_q  <= owner_d;
    seg_q    <= seg_d;
    tgt_q    <= tgt_d;
    status_q <= status_d;
    grp_q    <= grp_d;
    ev_q     <= ev_d;
    evown_q  <= evown_d;
    evseg_q  <= evseg_d;
  end

  // sequencer: initialize the list, then per item read the entry, unlink it, rewrite it, relink it
  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    skip_d   = skip_q;
    done_d   = 1'b0;
    op_d     = op_q;
    owner_d  = owner_q;
    seg_d    = seg_q;
    tgt_d    = tgt_q;
    status_d = status_q;
    grp_d    = grp_q;
    ev_d     = ev_q;
    evown_d  = evown_q;
    evseg_d  = evseg_q;
    rd_en    = 1'b0;
    rd_addr  = tgt_q;
    we       = '0;
    wr_addr  = tgt_q;
    wr_next  = LinkNone;
    wr_prev  = LinkNone;
    wr_owner = '0;
    wr_seg   = '0;
    wr_inl   = 1'b0;
    wr_pin   = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        // write entries in ascending order, linking the list from the highest index down
        we      = '{nxt: 1'b1, prv: 1'b1, attr: 1'b1};
        wr_addr = init_q;
        wr_next = (init_q == '0) ? LinkNone : LinkW'(init_q) - LinkW'(1);
        wr_prev = (init_q == LastIdx) ? LinkNone : LinkW'(init_q) + LinkW'(1);
        wr_inl  = 1'b1;
        init_d  = init_q + IdxW'(1);
        if (init_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          op_d    = in_op;
          owner_d = owner_wrap;
          seg_d   = seg_wrap;
          tgt_d   = in_alloc ? head_q[IdxW-1:0] : entry_index_i;
          skip_d  = in_alloc ? (head_q == LinkNone) :
                               (LinkW'(entry_index_i) >= LinkNone);
          rd_en   = !skip_d;
          rd_addr = tgt_d;
          state_d = ST_FETCH;
        end
      end

      ST_FETCH: begin
        // unlink from the predecessor side, fix head and tail
        if (!skip_q && rd_inl) begin
          if (rd_prev != LinkNone) begin
            we.nxt  = 1'b1;
            wr_addr = rd_prev[IdxW-1:0];
            wr_next = rd_next;
          end else begin
            head_d = rd_next;
          end
          if (rd_next == LinkNone) begin
            tail_d = rd_prev;
          end
        end
        state_d = ST_UNLINK;
      end

      ST_UNLINK: begin
        // unlink from the successor side
        if (!skip_q && rd_inl && (rd_next != LinkNone)) begin
          we.prv  = 1'b1;
          wr_addr = rd_next[IdxW-1:0];
          wr_prev = rd_prev;
        end
        state_d = ST_ENTRY;
      end

      ST_ENTRY: begin
        // rewrite the entry itself
        if (!skip_q) begin
          we = '{nxt: 1'b1, prv: 1'b1, attr: 1'b1};
          case (op_q) inside
            OP_ALLOC: begin
              wr_prev  = (owner_q != '0) ? tail_q : LinkNone;
              wr_owner = owner_q;
              wr_seg   = seg_q;
              wr_inl   = (owner_q != '0);
              wr_pin   = rd_pin;
            end
            OP_FREE: begin
              wr_next = head_q;
              wr_seg  = rd_seg;
              wr_inl  = 1'b1;
              if (rd_pin && (cnt_q != '0)) begin
                cnt_d = cnt_q - CntW'(1);
              end
            end
            OP_ALLOC_RSV, OP_RESERVE: begin
              wr_pin = 1'b1;
              if (!rd_pin) begin
                cnt_d = cnt_q + CntW'(1);
              end
            end
            default: begin
              we = '0;
            end
          endcase
        end
        state_d = ST_ENTRY == state_q ? ST_RELINK : ST_IDLE;
      end

      ST_RELINK: begin
        // link the entry back in for a free or an allocation to a nonzero owner, and post the result
        if (!skip_q) begin
          if ((op_q == OP_ALLOC) && (owner_q != '0)) begin
            if (tail_q != LinkNone) begin
              we.nxt  = 1'b1;
              wr_addr = tail_q[IdxW-1:0];
              wr_next = LinkW'(tgt_q);
            end else begin
              head_d = LinkW'(tgt_q);
            end
            tail_d = LinkW'(tgt_q);
          end else if (op_q == OP_FREE) begin
            if (head_q != LinkNone) begin
              we.prv  = 1'b1;
              wr_addr = head_q[IdxW-1:0];
              wr_prev = LinkW'(tgt_q);
            end else begin
              tail_d = LinkW'(tgt_q);
            end
            head_d = LinkW'(tgt_q);
          end
        end
        done_d   = 1'b1;
        status_d = alloc_q && skip_q;
        grp_d    = (alloc_q && skip_q) ? '0 : tgt_q;
        ev_d     = alloc_q && !skip_q && (rd_owner != '0);
        evown_d  = ev_d ? rd_owner : '0;
        evseg_d  = ev_d ? rd_seg : '0;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign group_index_o     = grp_q;
  assign evicted_o         = ev_q;
  assign evicted_owner_o   = evown_q;
  assign evicted_segment_o = evseg_q;
  assign reserved_count_o  = cnt_q;

endmodule

>>> sv/pgl_checker.sv
`timescale 1ns / 1ps

module pgl_checker #(
  parameter int unsigned GROUPS   = pgl_pkg::GROUPS_DEF,
  parameter int unsigned OWNERS   = pgl_pkg::OWNERS_DEF,
  parameter int unsigned SEGMENTS = pgl_pkg::SEGMENTS_DEF,
  localparam int unsigned IdxW  = $clog2(GROUPS),
  localparam int unsigned CntW  = $clog2(GROUPS + 1),
  localparam int unsigned OwnW  = $clog2(OWNERS),
  localparam int unsigned SegW  = $clog2(SEGMENTS)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            done_o,
  input logic            status_o,
  input logic [IdxW-1:0] group_index_o,
  input logic            evicted_o,
  input logic [OwnW-1:0] evicted_owner_o,
  input logic [SegW-1:0] evicted_segment_o,
  input logic [CntW-1:0] reserved_count_o
);
  import pgl_pkg::*;

  // an accepted item reports its result on done_o
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("result not posted five cycles after accept");

  // a result is only shown while the block is free
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result posted while busy");

  // an empty-list result carries no group and no eviction
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (!evicted_o && (group_index_o == '0)))
    else $error("empty-list result carries a group");

  // eviction fields are zero whenever no eviction is flagged
  a_evict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> ((evicted_owner_o == '0) && (evicted_segment_o == '0)))
    else $error("eviction fields set without eviction");

  // the pin count shown with a result never exceeds the pool
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (reserved_count_o <= CntW'(GROUPS)))
    else $error("reserved count beyond pool size");

endmodule

bind page_group_lru_allocator pgl_checker #(
  .GROUPS   (GROUPS),
  .OWNERS   (OWNERS),
  .SEGMENTS (SEGMENTS)
) u_pgl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .status_o          (status_o),
  .group_index_o     (group_index_o),
  .evicted_o         (evicted_o),
  .evicted_owner_o   (evicted_owner_o),
  .evicted_segment_o (evicted_segment_o),
  .reserved_count_o  (reserved_count_o)
);
